>>> design/awbg_pkg.sv
`default_nettype none

package awbg_pkg;

    // field widths
    localparam int RATIO_W  = 16;
    localparam int STATUS_W = 2;

    // fixed-point constants: ratio 512 is 1.0, gain 256 is unity
    localparam int RATIO_SHIFT = 9;
    localparam int GAIN_SHIFT  = 8;
    localparam logic [RATIO_W-1:0] UNITY_GAIN = 16'h0100;

    // first divide: (gold << 9) / meas
    localparam int Q1_W = RATIO_W + RATIO_SHIFT;
    // second divide: up to (ratio << 8) / ratio, or (256*512) / ratio
    localparam int Q2_W = RATIO_W + GAIN_SHIFT;
    localparam logic [Q2_W-1:0] GAIN_NUM = Q2_W'(1 << (GAIN_SHIFT + RATIO_SHIFT));

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_INPUT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_RATIO = 2'd2;

    // lanes of the second divider
    localparam int L_G_R  = 0;  // 131072 / r
    localparam int L_G_B  = 1;  // 131072 / b
    localparam int L_B_R  = 2;  // 256*b / r
    localparam int L_R_B  = 3;  // 256*r / b
    localparam int LANES2 = 4;

    localparam int SIDE2_W = STATUS_W + 2 * RATIO_W;

endpackage

`default_nettype wire

>>> design/awbg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per pipeline stage, several lanes
// sharing one valid and one sideband word.
module awbg_div
    import awbg_pkg::*;
#(
    parameter int NUM_W  = 25,
    parameter int DEN_W  = 16,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_vld,
    input  wire logic [NUM_W-1:0]  in_num  [LANES],
    input  wire logic [DEN_W-1:0]  in_den  [LANES],
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_vld,
    output logic [NUM_W-1:0]       out_quo [LANES],
    output logic [SIDE_W-1:0]      out_side
);

    logic [NUM_W-1:0]  vld_reg;
    logic [NUM_W-1:0]  num_reg  [NUM_W][LANES];
    logic [NUM_W-1:0]  num_next [NUM_W][LANES];
    logic [DEN_W-1:0]  rem_reg  [NUM_W][LANES];
    logic [DEN_W-1:0]  rem_next [NUM_W][LANES];
    logic [NUM_W-1:0]  quo_reg  [NUM_W][LANES];
    logic [NUM_W-1:0]  quo_next [NUM_W][LANES];
    logic [DEN_W-1:0]  den_reg  [NUM_W][LANES];
    logic [DEN_W-1:0]  den_next [NUM_W][LANES];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic [SIDE_W-1:0] side_next[NUM_W];
    logic [NUM_W-1:0]  vld_next;

    // one trial subtract per stage and lane
    always_comb
    begin
        logic [NUM_W-1:0] n_src;
        logic [DEN_W-1:0] r_src;
        logic [NUM_W-1:0] q_src;
        logic [DEN_W-1:0] d_src;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             qbit;
        for (int s = 0; s < NUM_W; s++)
        begin
            if (s == 0)
            begin
                vld_next[s]  = in_vld;
                side_next[s] = in_side;
            end
            else
            begin
                vld_next[s]  = vld_reg[s-1];
                side_next[s] = side_reg[s-1];
            end
            for (int l = 0; l < LANES; l++)
            begin
                if (s == 0)
                begin
                    n_src = in_num[l];
                    r_src = '0;
                    q_src = '0;
                    d_src = in_den[l];
                end
                else
                begin
                    n_src = num_reg[s-1][l];
                    r_src = rem_reg[s-1][l];
                    q_src = quo_reg[s-1][l];
                    d_src = den_reg[s-1][l];
                end
                trial = {r_src, n_src[NUM_W-1]};
                diff  = trial - {1'b0, d_src};
                qbit  = (trial >= {1'b0, d_src});
                rem_next[s][l] = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_next[s][l] = {n_src[NUM_W-2:0], 1'b0};
                quo_next[s][l] = {q_src[NUM_W-2:0], qbit};
                den_next[s][l] = d_src;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg <= side_next;
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
        end
    end

    assign out_vld  = vld_reg[NUM_W-1];
    assign out_quo  = quo_reg[NUM_W-1];
    assign out_side = side_reg[NUM_W-1];

endmodule

`default_nettype wire

>>> design/awbg_out.sv
`default_nettype none

// Case selection, truncation and the output register.
module awbg_out
    import awbg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_vld,
    input  wire logic [Q2_W-1:0]     in_quo [LANES2],
    input  wire logic [SIDE2_W-1:0]  in_side,
    output logic                     out_vld,
    output logic [STATUS_W-1:0]      out_status,
    output logic [RATIO_W-1:0]       out_red,
    output logic [RATIO_W-1:0]       out_green,
    output logic [RATIO_W-1:0]       out_blue,
    output logic                     out_ovf
);

    logic                vld_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [RATIO_W-1:0]  red_reg, red_next;
    logic [RATIO_W-1:0]  green_reg, green_next;
    logic [RATIO_W-1:0]  blue_reg, blue_next;
    logic                ovf_reg, ovf_next;

    logic [RATIO_W-1:0]  r_ratio;
    logic [RATIO_W-1:0]  b_ratio;
    logic                r_ge;
    logic                b_ge;
    logic                use_r;

    assign status_next = in_side[SIDE2_W-1 -: STATUS_W];
    assign r_ratio     = in_side[2*RATIO_W-1 -: RATIO_W];
    assign b_ratio     = in_side[RATIO_W-1:0];
    assign r_ge        = (r_ratio[RATIO_W-1:RATIO_SHIFT] != '0);
    assign b_ge        = (b_ratio[RATIO_W-1:RATIO_SHIFT] != '0);
    // divide by the smaller ratio; ties on truncated green go to red
    assign use_r = !r_ge && (b_ge ||
                   (in_quo[L_G_R][RATIO_W-1:0] >= in_quo[L_G_B][RATIO_W-1:0]));

    // gain selection
    always_comb
    begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        ovf_next   = 1'b0;
        if (status_next == ST_OK)
        begin
            if (r_ge && b_ge)
            begin
                red_next   = {1'b0, r_ratio[RATIO_W-1:1]};
                green_next = UNITY_GAIN;
                blue_next  = {1'b0, b_ratio[RATIO_W-1:1]};
            end
            else if (use_r)
            begin
                red_next   = UNITY_GAIN;
                green_next = in_quo[L_G_R][RATIO_W-1:0];
                blue_next  = in_quo[L_B_R][RATIO_W-1:0];
                ovf_next   = (in_quo[L_G_R][Q2_W-1:RATIO_W] != '0) ||
                             (in_quo[L_B_R][Q2_W-1:RATIO_W] != '0);
            end
            else
            begin
                red_next   = in_quo[L_R_B][RATIO_W-1:0];
                green_next = in_quo[L_G_B][RATIO_W-1:0];
                blue_next  = UNITY_GAIN;
                ovf_next   = (in_quo[L_R_B][Q2_W-1:RATIO_W] != '0) ||
                             (in_quo[L_G_B][Q2_W-1:RATIO_W] != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= status_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign out_vld    = vld_reg;
    assign out_status = status_reg;
    assign out_red    = red_reg;
    assign out_green  = green_reg;
    assign out_blue   = blue_reg;
    assign out_ovf    = ovf_reg;

endmodule

`default_nettype wire

>>> design/awb_channel_gain_calc.sv
// AWB channel gain calculator.
// Input channel (in_valid / in_stall) carries one request: measured and
// golden R/G and B/G ratios. Output channel (out_valid / out_stall) returns
// one result per request: status, red/green/blue gains (256 = unity, low
// 16 bits) and an overflow flag.
// Throughput: one request per cycle when the output is not stalled.
// From acceptance to out_valid, the first divider takes
// 25 stages (one quotient bit each, for 512*gold/meas), the second 24
// stages (four lanes for the gain quotients), and the output register
// stage selects and registers the result.
// The whole pipeline advances together. While a result is held on the
// output with out_stall high, the pipeline freezes and in_stall is high;
// nothing is lost or repeated. Bubbles ride along with their valid bits.
// Reset clears all valid bits; the block is ready right after reset.
// Status 1 flags a zero input, status 2 a zero wrapped ratio; the gains
// and flag are zero in both.
`default_nettype none

module awb_channel_gain_calc
    import awbg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [RATIO_W-1:0]  meas_rg,
    input  wire logic [RATIO_W-1:0]  meas_bg,
    input  wire logic [RATIO_W-1:0]  gold_rg,
    input  wire logic [RATIO_W-1:0]  gold_bg,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [RATIO_W-1:0]       red_gain,
    output logic [RATIO_W-1:0]       green_gain,
    output logic [RATIO_W-1:0]       blue_gain,
    output logic                     gain_overflow
);

    logic                adv;
    logic [Q1_W-1:0]     d1_num [2];
    logic [RATIO_W-1:0]  d1_den [2];
    logic                zero_in;
    logic                d1_vld;
    logic [Q1_W-1:0]     d1_quo [2];
    logic                d1_zero;
    logic [RATIO_W-1:0]  r_ratio;
    logic [RATIO_W-1:0]  b_ratio;
    logic [STATUS_W-1:0] st;
    logic [Q2_W-1:0]     d2_num [LANES2];
    logic [RATIO_W-1:0]  d2_den [LANES2];
    logic [SIDE2_W-1:0]  d2_side;
    logic                d2_vld;
    logic [Q2_W-1:0]     d2_quo [LANES2];
    logic [SIDE2_W-1:0]  d2_side_out;

    // global advance: freeze only while a result waits
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // first divide: wrapped correction ratios
    assign zero_in   = (meas_rg == '0) || (meas_bg == '0) ||
                       (gold_rg == '0) || (gold_bg == '0);
    assign d1_num[0] = {gold_rg, {RATIO_SHIFT{1'b0}}};
    assign d1_num[1] = {gold_bg, {RATIO_SHIFT{1'b0}}};
    assign d1_den[0] = meas_rg;
    assign d1_den[1] = meas_bg;

    awbg_div #(
        .NUM_W  (Q1_W),
        .DEN_W  (RATIO_W),
        .LANES  (2),
        .SIDE_W (1)
    ) u_div_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (in_valid),
        .in_num   (d1_num),
        .in_den   (d1_den),
        .in_side  (zero_in),
        .out_vld  (d1_vld),
        .out_quo  (d1_quo),
        .out_side (d1_zero)
    );

    // status and second divide operands
    assign r_ratio = d1_quo[0][RATIO_W-1:0];
    assign b_ratio = d1_quo[1][RATIO_W-1:0];

    always_comb
    begin
        if (d1_zero)
        begin
            st = ST_ZERO_INPUT;
        end
        else if ((r_ratio == '0) || (b_ratio == '0))
        begin
            st = ST_ZERO_RATIO;
        end
        else
        begin
            st = ST_OK;
        end
    end

    assign d2_num[L_G_R] = GAIN_NUM;
    assign d2_den[L_G_R] = r_ratio;
    assign d2_num[L_G_B] = GAIN_NUM;
    assign d2_den[L_G_B] = b_ratio;
    assign d2_num[L_B_R] = {b_ratio, {GAIN_SHIFT{1'b0}}};
    assign d2_den[L_B_R] = r_ratio;
    assign d2_num[L_R_B] = {r_ratio, {GAIN_SHIFT{1'b0}}};
    assign d2_den[L_R_B] = b_ratio;
    assign d2_side       = {st, r_ratio, b_ratio};

    awbg_div #(
        .NUM_W  (Q2_W),
        .DEN_W  (RATIO_W),
        .LANES  (LANES2),
        .SIDE_W (SIDE2_W)
    ) u_div_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (d1_vld),
        .in_num   (d2_num),
        .in_den   (d2_den),
        .in_side  (d2_side),
        .out_vld  (d2_vld),
        .out_quo  (d2_quo),
        .out_side (d2_side_out)
    );

    awbg_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_vld     (d2_vld),
        .in_quo     (d2_quo),
        .in_side    (d2_side_out),
        .out_vld    (out_valid),
        .out_status (status),
        .out_red    (red_gain),
        .out_green  (green_gain),
        .out_blue   (blue_gain),
        .out_ovf    (gain_overflow)
    );

endmodule

`default_nettype wire

>>> design/awbg_chk.sv
`default_nettype none

module awbg_chk
    import awbg_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [RATIO_W-1:0]  red_gain,
    input wire logic [RATIO_W-1:0]  green_gain,
    input wire logic [RATIO_W-1:0]  blue_gain,
    input wire logic                gain_overflow
);

    // a held result freezes the pipeline, so no request may enter
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("request accepted while output held");

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_gain) &&
        $stable(green_gain) && $stable(blue_gain) && $stable(status))
        else $error("held result changed");

    // error results carry zero gains
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (red_gain == '0) &&
        (green_gain == '0) && (blue_gain == '0) && !gain_overflow)
        else $error("error result with nonzero gains");

    // a good result has at least one unity channel
    a_unity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |-> (red_gain == UNITY_GAIN) ||
        (green_gain == UNITY_GAIN) || (blue_gain == UNITY_GAIN))
        else $error("no unity gain channel");

endmodule

bind awb_channel_gain_calc awbg_chk u_awbg_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .red_gain      (red_gain),
    .green_gain    (green_gain),
    .blue_gain     (blue_gain),
    .gain_overflow (gain_overflow)
);

`default_nettype wire
